@@ hw/rtl/sfpp_pkg.sv @@
// shared types and constants for the sync framed packet parser
// no dependencies; compile first
`default_nettype none

package sfpp_pkg;

  // largest payload the parser will ever accept, whatever the limit register says
  localparam logic [10:0] MaxPayload = 11'd1024;

  // reset values of the configuration registers
  localparam logic [7:0]  SyncFirstRst    = 8'd181;
  localparam logic [7:0]  SyncSecondRst   = 8'd98;
  localparam logic [10:0] PayloadLimitRst = 11'd1024;

  // parser phase
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_e;

  // event code of a result word
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PAYLOAD  = 3'd1,
    EV_OK       = 3'd2,
    EV_SYNC     = 3'd3,
    EV_OVERFLOW = 3'd4,
    EV_CKFAIL   = 3'd5
  } event_e;

  // configuration register index (byte address / 4)
  typedef enum logic [1:0] {
    REG_SYNC_FIRST    = 2'd0,
    REG_SYNC_SECOND   = 2'd1,
    REG_PAYLOAD_LIMIT = 2'd2
  } reg_idx_e;

  // configuration seen by the parser
  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [10:0] payload_limit;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/sfpp_if.sv @@
// valid/ready channel interfaces for the parser: received bytes in, results out
// depends on sfpp_pkg
`default_nettype none

// received byte channel
interface sfpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface sfpp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;
  logic [7:0]  payload_value;
  logic [9:0]  payload_offset;
  logic [31:0] good_frames;
  logic [31:0] sync_faults;
  logic [31:0] length_overflows;
  logic [31:0] checksum_failures;

  modport source (output valid, output event_res, output frame_class, output frame_id,
                  output frame_length, output payload_value, output payload_offset,
                  output good_frames, output sync_faults, output length_overflows,
                  output checksum_failures, input ready);
  modport sink   (input valid, input event_res, input frame_class, input frame_id,
                  input frame_length, input payload_value, input payload_offset,
                  input good_frames, input sync_faults, input length_overflows,
                  input checksum_failures, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sfpp_cfg_regs.sv @@
// apb configuration registers of the parser: sync bytes and payload limit
// depends on sfpp_pkg
`default_nettype none

module sfpp_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output sfpp_pkg::cfg_t     cfg_o
);
  import sfpp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SYNC_FIRST:    cfg_d.sync_first    = pwdata[7:0];
        REG_SYNC_SECOND:   cfg_d.sync_second   = pwdata[7:0];
        REG_PAYLOAD_LIMIT: cfg_d.payload_limit = pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= SyncFirstRst;
      cfg_q.sync_second   <= SyncSecondRst;
      cfg_q.payload_limit <= PayloadLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_SYNC_FIRST:    prdata = {24'd0, cfg_q.sync_first};
      REG_SYNC_SECOND:   prdata = {24'd0, cfg_q.sync_second};
      REG_PAYLOAD_LIMIT: prdata = {21'd0, cfg_q.payload_limit};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/sync_framed_packet_parser_fletcher8.sv @@
// top level of the sync framed packet parser with 8-bit fletcher checksum
// depends on sfpp_pkg, sfpp_if (sfpp_in_if, sfpp_out_if) and sfpp_cfg_regs
//
// usage: one received byte enters per word on in_i; every byte gives exactly one
// result word on out_o carrying an event code (none, payload byte, frame ok,
// sync error, length overflow, checksum fail), the current frame class, id and
// length, the payload byte with its offset, and four wrapping 32-bit counters.
// the byte is captured in an input register, then the parser phase and checksum
// update and the result register loads. throughput is one byte per cycle while
// out_o does not stall; when it stalls, the result holds and the parser state
// freezes; one more byte is taken into the input register, then in_i.ready
// drops until the result is taken. reset empties both registers, clears frame
// fields, sums and counters, sets the phase to hunting for the first sync byte
// and restores sync bytes 0xb5/0x62 and the payload limit 1024. the apb port
// (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds the sync bytes
// at 0x0 and 0x4 and the payload limit at 0x8; write it only while the parser
// is idle.
`default_nettype none

module sync_framed_packet_parser_fletcher8 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  sfpp_in_if.sink          in_i,
  sfpp_out_if.source       out_o
);
  import sfpp_pkg::*;

  cfg_t cfg;

  sfpp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       advance;

  assign advance    = in_vld_q & (~out_o.valid | out_o.ready);
  assign in_i.ready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid & in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid & in_i.ready) begin
      byte_q <= in_i.rx_byte;
    end
  end

  // parser state
  phase_e      phase_q, phase_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [10:0] pos_q, pos_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  rx_a_q, rx_a_d;
  logic [31:0] good_q, good_d;
  logic [31:0] sync_q, sync_d;
  logic [31:0] ovf_q, ovf_d;
  logic [31:0] ckf_q, ckf_d;

  // result register
  logic        out_vld_q;
  event_e      ev_q, ev_d;
  logic [7:0]  pval_q, pval_d;
  logic [9:0]  poff_q, poff_d;

  logic [7:0]  add_a, add_b;
  logic [10:0] limit;
  logic [15:0] len_full;
  logic [10:0] pos_inc;

  // running fletcher sums with the current byte, effective length limit
  assign add_a    = sum_a_q + byte_q;
  assign add_b    = sum_b_q + add_a;
  assign limit    = (cfg.payload_limit > MaxPayload) ? MaxPayload : cfg.payload_limit;
  assign len_full = {byte_q, len_q[7:0]};
  assign pos_inc  = pos_q + 11'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_SYNC1:   if (byte_q == cfg.sync_first) phase_d = PH_SYNC2;
      PH_SYNC2:   phase_d = (byte_q == cfg.sync_second) ? PH_CLASS : PH_SYNC1;
      PH_CLASS:   phase_d = PH_ID;
      PH_ID:      phase_d = PH_LEN1;
      PH_LEN1:    phase_d = PH_LEN2;
      PH_LEN2: begin
        if (len_full > {5'd0, limit})  phase_d = PH_SYNC1;
        else if (len_full == 16'd0)    phase_d = PH_CKA;
        else                           phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: if ({5'd0, pos_inc} >= len_q) phase_d = PH_CKA;
      PH_CKA:     phase_d = PH_CKB;
      PH_CKB:     phase_d = PH_SYNC1;
      default:    phase_d = PH_SYNC1;
    endcase
  end

  // datapath and result for the byte in the input register
  always_comb begin
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    pos_d   = pos_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    rx_a_d  = rx_a_q;
    good_d  = good_q;
    sync_d  = sync_q;
    ovf_d   = ovf_q;
    ckf_d   = ckf_q;
    ev_d    = EV_NONE;
    pval_d  = 8'd0;
    poff_d  = 10'd0;
    unique case (phase_q)
      PH_SYNC1: ;
      PH_SYNC2: begin
        if (byte_q != cfg.sync_second) begin
          sync_d = sync_q + 32'd1;
          ev_d   = EV_SYNC;
        end
      end
      PH_CLASS: begin
        class_d = byte_q;
        sum_a_d = byte_q;
        sum_b_d = byte_q;
      end
      PH_ID: begin
        id_d    = byte_q;
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      PH_LEN1: begin
        len_d   = {8'd0, byte_q};
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      PH_LEN2: begin
        len_d   = len_full;
        sum_a_d = add_a;
        sum_b_d = add_b;
        pos_d   = 11'd0;
        if (len_full > {5'd0, limit}) begin
          ovf_d = ovf_q + 32'd1;
          ev_d  = EV_OVERFLOW;
        end
      end
      PH_PAYLOAD: begin
        ev_d    = EV_PAYLOAD;
        pval_d  = byte_q;
        poff_d  = pos_q[9:0];
        sum_a_d = add_a;
        sum_b_d = add_b;
        pos_d   = pos_inc;
      end
      PH_CKA: rx_a_d = byte_q;
      PH_CKB: begin
        if ((rx_a_q == sum_a_q) && (byte_q == sum_b_q)) begin
          good_d = good_q + 32'd1;
          ev_d   = EV_OK;
        end else begin
          ckf_d = ckf_q + 32'd1;
          ev_d  = EV_CKFAIL;
        end
      end
      default: ;
    endcase
  end

  // state update, only when a byte moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      class_q <= 8'd0;
      id_q    <= 8'd0;
      len_q   <= 16'd0;
      pos_q   <= 11'd0;
      sum_a_q <= 8'd0;
      sum_b_q <= 8'd0;
      rx_a_q  <= 8'd0;
      good_q  <= 32'd0;
      sync_q  <= 32'd0;
      ovf_q   <= 32'd0;
      ckf_q   <= 32'd0;
    end else if (advance) begin
      phase_q <= phase_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      rx_a_q  <= rx_a_d;
      good_q  <= good_d;
      sync_q  <= sync_d;
      ovf_q   <= ovf_d;
      ckf_q   <= ckf_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q   <= ev_d;
      pval_q <= pval_d;
      poff_q <= poff_d;
    end
  end

  // frame fields and counters are parser state, frozen while the result waits
  assign out_o.valid             = out_vld_q;
  assign out_o.event_res         = ev_q;
  assign out_o.frame_class       = class_q;
  assign out_o.frame_id          = id_q;
  assign out_o.frame_length      = len_q;
  assign out_o.payload_value     = pval_q;
  assign out_o.payload_offset    = poff_q;
  assign out_o.good_frames       = good_q;
  assign out_o.sync_faults       = sync_q;
  assign out_o.length_overflows  = ovf_q;
  assign out_o.checksum_failures = ckf_q;

endmodule

`default_nettype wire

@@ sim/sync_framed_packet_parser_fletcher8_test.sv @@
// testbench for sync_framed_packet_parser_fletcher8: streams framed byte sequences,
// predicts every result word in step with the input and checks it field by field
// depends on sfpp_pkg, sfpp_if and the parser rtl
`default_nettype none

module sync_framed_packet_parser_fletcher8_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfpp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0]  RegUnused  = 2'd3;

  // ways a generated frame can be spoiled
  typedef enum logic [2:0] {
    FLAW_NONE,
    FLAW_SYNC,
    FLAW_CKA,
    FLAW_CKB,
    FLAW_CUT
  } frame_flaw_e;

  // receiver ready patterns
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARE,
    RDY_PERIODIC
  } ready_mode_e;

  typedef struct {
    event_e      ev;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [7:0]  pval;
    logic [9:0]  poff;
    logic [31:0] good;
    logic [31:0] sync_err;
    logic [31:0] ovf;
    logic [31:0] ck_err;
  } parse_result_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        src_valid  = 1'b0;
  logic [7:0]  src_byte   = '0;
  logic        sink_ready = 1'b0;

  logic [7:0]    pending_bytes[$];
  parse_result_t awaited_results[$];
  int unsigned   bytes_queued = 0;
  int unsigned   bytes_taken  = 0;
  int unsigned   error_count  = 0;
  logic [31:0]   cycle_cnt    = '0;

  int unsigned   gap_left   = 0;
  int unsigned   burst_left = 0;
  int unsigned   stall_left = 0;
  ready_mode_e   stall_mode = RDY_ALWAYS;

  // parser copy: configuration and state
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [10:0] limit_reg;
  phase_e      parse_phase;
  logic [7:0]  cur_class;
  logic [7:0]  cur_id;
  logic [15:0] cur_length;
  logic [10:0] body_idx;
  logic [7:0]  fl_a;
  logic [7:0]  fl_b;
  logic [7:0]  rx_ck_a;
  logic [31:0] good_count;
  logic [31:0] sync_count;
  logic [31:0] ovf_count;
  logic [31:0] ckfail_count;

  sfpp_in_if  in_if ();
  sfpp_out_if out_if ();

  assign in_if.valid   = src_valid;
  assign in_if.rx_byte = src_byte;
  assign out_if.ready  = sink_ready;

  sync_framed_packet_parser_fletcher8 u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 32'd1;
  end

  // run-away guard
  initial begin
    wait (cycle_cnt == CycleLimit);
    $display("sync_framed_packet_parser_fletcher8 regression: fail");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // payload length the parser really accepts
  function automatic logic [15:0] eff_limit();
    return {5'd0, (limit_reg > MaxPayload) ? MaxPayload : limit_reg};
  endfunction

  function automatic void clear_parser();
    sync_first   = SyncFirstRst;
    sync_second  = SyncSecondRst;
    limit_reg    = PayloadLimitRst;
    parse_phase  = PH_SYNC1;
    cur_class    = '0;
    cur_id       = '0;
    cur_length   = '0;
    body_idx     = '0;
    fl_a         = '0;
    fl_b         = '0;
    rx_ck_a      = '0;
    good_count   = '0;
    sync_count   = '0;
    ovf_count    = '0;
    ckfail_count = '0;
  endfunction

  function automatic void fletcher_add(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endfunction

  // advance the parser copy by one byte and return the word it must produce
  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    r.ev   = EV_NONE;
    r.pval = '0;
    r.poff = '0;
    case (parse_phase)
      PH_SYNC1: begin
        if (b == sync_first) parse_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == sync_second) begin
          parse_phase = PH_CLASS;
        end else begin
          sync_count  = sync_count + 32'd1;
          r.ev        = EV_SYNC;
          parse_phase = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        cur_class   = b;
        fl_a        = b;
        fl_b        = b;
        parse_phase = PH_ID;
      end
      PH_ID: begin
        cur_id = b;
        fletcher_add(b);
        parse_phase = PH_LEN1;
      end
      PH_LEN1: begin
        cur_length = {8'd0, b};
        fletcher_add(b);
        parse_phase = PH_LEN2;
      end
      PH_LEN2: begin
        cur_length = {b, cur_length[7:0]};
        fletcher_add(b);
        body_idx = '0;
        if (cur_length > eff_limit()) begin
          ovf_count   = ovf_count + 32'd1;
          r.ev        = EV_OVERFLOW;
          parse_phase = PH_SYNC1;
        end else if (cur_length == 16'd0) begin
          parse_phase = PH_CKA;
        end else begin
          parse_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.ev   = EV_PAYLOAD;
        r.pval = b;
        r.poff = body_idx[9:0];
        fletcher_add(b);
        body_idx = body_idx + 11'd1;
        if ({5'd0, body_idx} >= cur_length) parse_phase = PH_CKA;
      end
      PH_CKA: begin
        rx_ck_a     = b;
        parse_phase = PH_CKB;
      end
      PH_CKB: begin
        if (rx_ck_a == fl_a && b == fl_b) begin
          good_count = good_count + 32'd1;
          r.ev       = EV_OK;
        end else begin
          ckfail_count = ckfail_count + 32'd1;
          r.ev         = EV_CKFAIL;
        end
        parse_phase = PH_SYNC1;
      end
      default: parse_phase = PH_SYNC1;
    endcase
    r.cls      = cur_class;
    r.id       = cur_id;
    r.len      = cur_length;
    r.good     = good_count;
    r.sync_err = sync_count;
    r.ovf      = ovf_count;
    r.ck_err   = ckfail_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    parse_result_t want;
    if (awaited_results.size() == 0) begin
      $error("result word with no byte outstanding");
      error_count++;
    end else begin
      want = awaited_results.pop_front();
      check_field("event_res", {29'd0, want.ev}, {29'd0, out_if.event_res});
      check_field("frame_class", {24'd0, want.cls}, {24'd0, out_if.frame_class});
      check_field("frame_id", {24'd0, want.id}, {24'd0, out_if.frame_id});
      check_field("frame_length", {16'd0, want.len}, {16'd0, out_if.frame_length});
      check_field("payload_value", {24'd0, want.pval}, {24'd0, out_if.payload_value});
      check_field("payload_offset", {22'd0, want.poff}, {22'd0, out_if.payload_offset});
      check_field("good_frames", want.good, out_if.good_frames);
      check_field("sync_faults", want.sync_err, out_if.sync_faults);
      check_field("length_overflows", want.ovf, out_if.length_overflows);
      check_field("checksum_failures", want.ck_err, out_if.checksum_failures);
    end
  endfunction

  // byte driver: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid  <= 1'b0;
      src_byte   <= '0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (src_valid && in_if.ready) begin
        awaited_results.push_back(parse_byte(src_byte));
        bytes_taken++;
      end
      if (!src_valid || in_if.ready) begin
        if (gap_left != 0 || pending_bytes.size() == 0) begin
          if (gap_left != 0) gap_left--;
          src_valid <= 1'b0;
        end else begin
          src_valid <= 1'b1;
          src_byte  <= pending_bytes.pop_front();
          if (burst_left != 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // result monitor with its own ready pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && sink_ready) check_result();
      if (stall_left == 0) begin
        stall_mode = ready_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        RDY_ALWAYS: sink_ready <= 1'b1;
        RDY_MOSTLY: sink_ready <= ($urandom_range(0, 3) != 0);
        RDY_RARE:   sink_ready <= ($urandom_range(0, 7) == 0);
        default:    sink_ready <= cycle_cnt[2];
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // build one frame for the current sync bytes and limit, optionally spoiled
  task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input frame_flaw_e flaw);
    logic [7:0]  body[$];
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  second;
    int unsigned keep;
    body.push_back(cls);
    body.push_back(id);
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    if (len <= eff_limit()) begin
      repeat (len) body.push_back(rand_byte());
    end
    sum_a = '0;
    sum_b = '0;
    foreach (body[k]) begin
      sum_a = sum_a + body[k];
      sum_b = sum_b + sum_a;
    end
    if (flaw == FLAW_CKA) sum_a = sum_a ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_CKB) sum_b = sum_b ^ 8'($urandom_range(1, 255));
    second = sync_second;
    if (flaw == FLAW_SYNC) begin
      while (second == sync_second) second = rand_byte();
    end
    if (len <= eff_limit()) begin
      body.push_back(sum_a);
      body.push_back(sum_b);
    end
    body.push_front(second);
    body.push_front(sync_first);
    keep = (flaw == FLAW_CUT) ? $urandom_range(3, body.size() - 1) : body.size();
    for (int i = 0; i < keep; i++) push_byte(body[i]);
  endtask

  // mostly well-formed frames, the rest noise and broken frames
  task automatic queue_random(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [15:0] lim;
    logic [15:0] len;
    frame_flaw_e flaw;
    stop_at = bytes_queued + budget;
    lim     = eff_limit();
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 12)) push_byte(rand_byte());
      end else if (pick < 16) begin
        if ($urandom_range(0, 1) == 0) len = lim + 16'd1;
        else len = 16'($urandom_range(32'(lim) + 1, 65535));
        queue_frame(rand_byte(), rand_byte(), len, FLAW_NONE);
      end else begin
        if (lim <= 16'd96 && $urandom_range(0, 7) == 0) len = lim;
        else len = 16'($urandom_range(0, (lim < 16'd16) ? 32'(lim) : 16));
        if (pick < 24)      flaw = FLAW_SYNC;
        else if (pick < 29) flaw = FLAW_CKA;
        else if (pick < 34) flaw = FLAW_CKB;
        else if (pick < 40) flaw = FLAW_CUT;
        else                flaw = FLAW_NONE;
        queue_frame(rand_byte(), rand_byte(), len, flaw);
      end
    end
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:    sync_first  = value[7:0];
      REG_SYNC_SECOND:   sync_second = value[7:0];
      REG_PAYLOAD_LIMIT: limit_reg   = value[10:0];
      default: ;
    endcase
  endtask

  // hold the sender until every queued byte has produced its word
  task automatic drain_results();
    do @(posedge clk_i);
    while (bytes_taken != bytes_queued || awaited_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_setting(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [10:0] lim, input int unsigned budget);
    drain_results();
    write_reg(REG_SYNC_FIRST, {24'd0, s1});
    write_reg(REG_SYNC_SECOND, {24'd0, s2});
    write_reg(REG_PAYLOAD_LIMIT, {21'd0, lim});
    write_reg(RegUnused, $urandom());
    queue_random(budget);
  endtask

  initial begin
    logic [7:0] shared_sync;
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: checksum failure on an empty frame, wrong second sync byte equal
    // to the first (not taken as a new start), short good frame, oversized length
    queue_frame(8'h00, 8'hff, 16'd0, FLAW_CKB);
    push_byte(sync_first);
    push_byte(sync_first);
    push_byte(sync_second);
    queue_frame(8'hff, 8'h00, 16'd2, FLAW_NONE);
    queue_frame(8'h5a, 8'ha5, {5'd0, MaxPayload} + 16'd1, FLAW_NONE);
    queue_random(120);

    // extreme sync values, payload limit 92
    run_setting(8'h00, 8'hff, 11'd92, 100);
    // limit above the hard maximum, plus one full-size frame
    run_setting(8'hff, 8'h00, 11'd2047, 100);
    queue_frame(rand_byte(), rand_byte(), {5'd0, MaxPayload}, FLAW_NONE);
    // identical sync bytes, tiny limit
    shared_sync = rand_byte();
    run_setting(shared_sync, shared_sync, 11'd5, 100);
    run_setting(rand_byte(), rand_byte(), 11'd1024, 100);
    // only empty frames fit
    run_setting(rand_byte(), rand_byte(), 11'd0, 60);

    drain_results();
    if (error_count == 0) begin
      $display("sync_framed_packet_parser_fletcher8 regression: pass");
    end else begin
      $display("sync_framed_packet_parser_fletcher8 regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
